FILE: src/bia_pkg.sv
package bia_pkg;

    localparam int CAPACITY   = 256;
    localparam int CHUNK_BITS = 64;
    localparam int NCHUNKS    = (CAPACITY + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int CHUNK_W    = (CHUNK_BITS > 1) ? $clog2(CHUNK_BITS) : 1;
    localparam int CW         = (NCHUNKS > 1) ? $clog2(NCHUNKS) : 1;

    localparam int IDX_W    = 9;
    localparam int STATUS_W = 2;

    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [STATUS_W-1:0]   status_t;
    typedef logic [CHUNK_BITS-1:0] word_t;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam status_t STATUS_OK       = 2'd0;
    localparam status_t STATUS_FULL     = 2'd1;
    localparam status_t STATUS_BAD_FREE = 2'd2;

    localparam idx_t CAP_RESET = idx_t'(256);
    localparam idx_t CAP_MAX   = idx_t'(CAPACITY);

    // bits j of a word whose position has bit k set
    function automatic word_t pos_mask(input int k);
        word_t m;
        m = '0;
        for (int j = 0; j < CHUNK_BITS; j++)
        begin
            m[j] = ((j >> k) & 1) == 1;
        end
        return m;
    endfunction

endpackage

FILE: src/bia_if.sv
interface bia_req_if;
    logic             valid;
    logic             ready;
    logic             kind;
    bia_pkg::idx_t    free_index;

    modport source (output valid, output kind, output free_index, input ready);
    modport sink   (input valid, input kind, input free_index, output ready);
endinterface

interface bia_rsp_if;
    logic             valid;
    logic             ready;
    bia_pkg::idx_t    alloc_index;
    bia_pkg::status_t status;
    bia_pkg::idx_t    high_water;

    modport source (output valid, output alloc_index, output status, output high_water,
                    input ready);
    modport sink   (input valid, input alloc_index, input status, input high_water,
                    output ready);
endinterface

interface bia_cfg_if;
    logic             valid;
    logic             ready;
    bia_pkg::idx_t    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: src/bitmap_index_allocator_core.sv
// channel  dir  beat payload                          accepted when
// req      in   kind, free_index                      req.valid && req.ready
// rsp      out  alloc_index, status, high_water       rsp.valid && rsp.ready
// cfg      in   data (capacity_in_use)                cfg.valid && cfg.ready
//
// Allocate: accepted in ST_IDLE, then one bitmap word per cycle through the
// find-first unit until a word holds a free bit or all NCHUNKS (4) are read;
// result registered on the last. Free: accept, then a check/update in ST_FREE.
// rst_n clears the bitmap to all free, high-water to 0, capacity to 256.
// req is ready only when idle and the result register is empty or draining;
// cfg is always ready.
module bitmap_index_allocator_core
(
    input  logic clk,
    input  logic rst_n,
    bia_req_if.sink   req,
    bia_rsp_if.source rsp,
    bia_cfg_if.sink   cfg
);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_FREE
    } state_t;

    state_t                 state_reg, state_next;
    logic [bia_pkg::CW-1:0] chunk_reg, chunk_next;
    bia_pkg::idx_t          fidx_reg, fidx_next;
    bia_pkg::word_t         map_reg [bia_pkg::NCHUNKS];
    bia_pkg::word_t         map_next [bia_pkg::NCHUNKS];
    bia_pkg::idx_t          hw_reg, hw_next;
    bia_pkg::idx_t          cap_reg, cap_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    bia_pkg::idx_t          rsp_index_reg, rsp_index_next;
    bia_pkg::status_t       rsp_status_reg, rsp_status_next;

    logic                        req_fire;
    bia_pkg::idx_t               cap_eff;
    bia_pkg::idx_t               fidx_m1;
    logic [bia_pkg::CW-1:0]      free_chunk;
    logic [bia_pkg::CHUNK_W-1:0] free_bit;
    logic [bia_pkg::CW-1:0]      rd_addr;
    bia_pkg::word_t              word;
    bia_pkg::word_t              iso;
    logic [bia_pkg::CHUNK_W-1:0] pos;
    bia_pkg::idx_t               cand;

    assign req.ready   = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign req_fire    = req.valid && req.ready;
    assign cfg.ready   = 1'b1;

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.alloc_index = rsp_index_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.high_water  = hw_reg;

    assign cap_eff    = (cap_reg > bia_pkg::CAP_MAX) ? bia_pkg::CAP_MAX : cap_reg;
    assign fidx_m1    = fidx_reg - 1'b1;
    assign free_chunk = fidx_m1[bia_pkg::CHUNK_W +: bia_pkg::CW];
    assign free_bit   = fidx_m1[bia_pkg::CHUNK_W-1:0];

    // find-first unit on one bitmap word; the word read is shared with free
    assign rd_addr = (state_reg == ST_FREE) ? free_chunk : chunk_reg;
    assign word    = map_reg[rd_addr];
    assign iso     = word & (~word + 1'b1);

    always_comb
    begin
        for (int k = 0; k < bia_pkg::CHUNK_W; k++)
        begin
            pos[k] = |(iso & bia_pkg::pos_mask(k));
        end
    end

    assign cand = bia_pkg::idx_t'({chunk_reg, pos}) + 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        chunk_next      = chunk_reg;
        fidx_next       = fidx_reg;
        map_next        = map_reg;
        hw_next         = hw_reg;
        cap_next        = cap_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_index_next  = rsp_index_reg;
        rsp_status_next = rsp_status_reg;

        if (cfg.valid && cfg.ready)
        begin
            cap_next = cfg.data;
        end

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    chunk_next = '0;
                    fidx_next  = req.free_index;
                    state_next = (req.kind == bia_pkg::KIND_FREE) ? ST_FREE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (word != '0)
                begin
                    state_next     = ST_IDLE;
                    rsp_valid_next = 1'b1;
                    if (cand <= cap_eff)
                    begin
                        map_next[rd_addr][pos] = 1'b0;
                        rsp_index_next  = cand;
                        rsp_status_next = bia_pkg::STATUS_OK;
                        if (cand > hw_reg)
                        begin
                            hw_next = cand;
                        end
                    end
                    else
                    begin
                        rsp_index_next  = '0;
                        rsp_status_next = bia_pkg::STATUS_FULL;
                    end
                end
                else if (chunk_reg == bia_pkg::CW'(bia_pkg::NCHUNKS - 1))
                begin
                    state_next      = ST_IDLE;
                    rsp_valid_next  = 1'b1;
                    rsp_index_next  = '0;
                    rsp_status_next = bia_pkg::STATUS_FULL;
                end
                else
                begin
                    chunk_next = chunk_reg + 1'b1;
                end
            end
            ST_FREE:
            begin
                state_next     = ST_IDLE;
                rsp_valid_next = 1'b1;
                rsp_index_next = '0;
                if (fidx_reg == '0 || fidx_reg > bia_pkg::CAP_MAX || word[free_bit])
                begin
                    rsp_status_next = bia_pkg::STATUS_BAD_FREE;
                end
                else
                begin
                    map_next[rd_addr][free_bit] = 1'b1;
                    rsp_status_next = bia_pkg::STATUS_OK;
                    if (fidx_reg == hw_reg)
                    begin
                        hw_next = hw_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chunk_reg     <= '0;
            hw_reg        <= '0;
            cap_reg       <= bia_pkg::CAP_RESET;
            rsp_valid_reg <= 1'b0;
            for (int c = 0; c < bia_pkg::NCHUNKS; c++)
            begin
                map_reg[c] <= '1;
            end
        end
        else
        begin
            state_reg     <= state_next;
            chunk_reg     <= chunk_next;
            hw_reg        <= hw_next;
            cap_reg       <= cap_next;
            rsp_valid_reg <= rsp_valid_next;
            map_reg       <= map_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fidx_reg       <= fidx_next;
        rsp_index_reg  <= rsp_index_next;
        rsp_status_reg <= rsp_status_next;
    end

endmodule

FILE: dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        bia_pkg::idx_t    alloc_index;
        bia_pkg::status_t status;
        bia_pkg::idx_t    high_water;
    } alloc_rsp_t;

    logic clk;
    logic rst_n;

    bia_req_if req_if ();
    bia_rsp_if rsp_if ();
    bia_cfg_if cfg_if ();

    bitmap_index_allocator_core u_top
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    // shadow allocator state
    bit [bia_pkg::CAPACITY-1:0] slot_free;
    bia_pkg::idx_t              hw_mark;
    bia_pkg::idx_t              cap_setting;
    int                         live_q[$];
    alloc_rsp_t                 expected_rsp_q[$];

    int     send_idle_pct;
    int     rsp_idle_pct;
    int     rsp_hold_left;
    int     errors;
    longint cycles;

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t timeout, %0d beats outstanding", $time, expected_rsp_q.size());
            $display("FAIL");
            $finish;
        end
    end

    // receiver ready, with an optional long hold-off
    always @(negedge clk)
    begin
        if (rsp_hold_left > 0)
        begin
            rsp_if.ready <= 1'b0;
            rsp_hold_left--;
        end
        else
        begin
            rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        alloc_rsp_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (expected_rsp_q.size() == 0)
            begin
                errors++;
                $display("%0t unexpected beat: alloc_index %0d status %0d high_water %0d",
                         $time, rsp_if.alloc_index, rsp_if.status, rsp_if.high_water);
            end
            else
            begin
                want = expected_rsp_q.pop_front();
                if (rsp_if.alloc_index !== want.alloc_index ||
                    rsp_if.status !== want.status ||
                    rsp_if.high_water !== want.high_water)
                begin
                    errors++;
                    $display("%0t mismatch: exp idx %0d st %0d hw %0d, got idx %0d st %0d hw %0d",
                             $time, want.alloc_index, want.status, want.high_water,
                             rsp_if.alloc_index, rsp_if.status, rsp_if.high_water);
                end
            end
        end
    end

    task automatic predict_request(input logic kind, input bia_pkg::idx_t idx);
        alloc_rsp_t r;
        int         lim;
        int         pos;
        bit         found;
        r = '0;
        if (kind == bia_pkg::KIND_ALLOC)
        begin
            lim = (cap_setting > bia_pkg::CAP_MAX) ? bia_pkg::CAPACITY : int'(cap_setting);
            found = 1'b0;
            for (int i = 1; i <= lim; i++)
            begin
                if (!found && slot_free[i-1])
                begin
                    found = 1'b1;
                    slot_free[i-1] = 1'b0;
                    r.alloc_index = bia_pkg::idx_t'(i);
                    live_q.push_back(i);
                end
            end
            if (found)
            begin
                r.status = bia_pkg::STATUS_OK;
                if (r.alloc_index > hw_mark)
                    hw_mark = r.alloc_index;
            end
            else
            begin
                r.status = bia_pkg::STATUS_FULL;
            end
        end
        else if (idx == 0 || idx > bia_pkg::CAP_MAX || slot_free[idx-1])
        begin
            r.status = bia_pkg::STATUS_BAD_FREE;
        end
        else
        begin
            r.status = bia_pkg::STATUS_OK;
            slot_free[idx-1] = 1'b1;
            pos = -1;
            foreach (live_q[k])
                if (live_q[k] == int'(idx))
                    pos = k;
            if (pos >= 0)
                live_q.delete(pos);
            if (idx == hw_mark)
                hw_mark = hw_mark - 1'b1;
        end
        r.high_water = hw_mark;
        expected_rsp_q.push_back(r);
    endtask

    // entered and left at a falling edge; valid stays high into the next beat
    task automatic send_req(input logic kind, input bia_pkg::idx_t idx);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.kind       <= kind;
        req_if.free_index <= idx;
        do
            @(posedge clk);
        while (!req_if.ready);
        predict_request(kind, idx);
        @(negedge clk);
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        while (expected_rsp_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_capacity(input bia_pkg::idx_t value);
        drain();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cap_setting = value;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic test_bad_frees();
        send_req(bia_pkg::KIND_FREE, bia_pkg::idx_t'(0));
        send_req(bia_pkg::KIND_FREE, bia_pkg::CAP_MAX);
        send_req(bia_pkg::KIND_FREE, bia_pkg::idx_t'(511));
        send_req(bia_pkg::KIND_FREE, bia_pkg::idx_t'(257));
        send_req(bia_pkg::KIND_FREE, bia_pkg::idx_t'(1));
    endtask

    task automatic test_alloc_free();
        send_req(bia_pkg::KIND_ALLOC, bia_pkg::idx_t'(0));
        send_req(bia_pkg::KIND_ALLOC, bia_pkg::idx_t'(511));
        send_req(bia_pkg::KIND_ALLOC, bia_pkg::idx_t'(0));
        send_req(bia_pkg::KIND_FREE, bia_pkg::idx_t'(3));
        send_req(bia_pkg::KIND_FREE, bia_pkg::idx_t'(1));
        send_req(bia_pkg::KIND_ALLOC, bia_pkg::idx_t'(0));
        send_req(bia_pkg::KIND_FREE, bia_pkg::idx_t'(2));
        send_req(bia_pkg::KIND_ALLOC, bia_pkg::idx_t'(0));
    endtask

    task automatic test_capacity_limits();
        write_capacity(bia_pkg::idx_t'(0));
        send_req(bia_pkg::KIND_ALLOC, bia_pkg::idx_t'(0));
        write_capacity(bia_pkg::idx_t'(4));
        repeat (3) send_req(bia_pkg::KIND_ALLOC, bia_pkg::idx_t'(0));
        // live index above a lowered capacity may still be freed
        write_capacity(bia_pkg::idx_t'(2));
        send_req(bia_pkg::KIND_FREE, bia_pkg::idx_t'(4));
        send_req(bia_pkg::KIND_ALLOC, bia_pkg::idx_t'(0));
        // above the store, acts as full capacity
        write_capacity(bia_pkg::idx_t'(511));
        send_req(bia_pkg::KIND_ALLOC, bia_pkg::idx_t'(0));
        for (int i = 4; i >= 1; i--)
            send_req(bia_pkg::KIND_FREE, bia_pkg::idx_t'(i));
        drain();
    endtask

    task automatic send_random(input int alloc_pct);
        bia_pkg::idx_t idx;
        idx = bia_pkg::idx_t'($urandom_range(511));
        if ($urandom_range(99) < alloc_pct)
        begin
            send_req(bia_pkg::KIND_ALLOC, idx);
        end
        else
        begin
            if (live_q.size() != 0 && $urandom_range(9) < 8)
                idx = bia_pkg::idx_t'(live_q[$urandom_range(live_q.size() - 1)]);
            else if ($urandom_range(1) == 1)
                idx = bia_pkg::idx_t'($urandom_range(256));
            send_req(bia_pkg::KIND_FREE, idx);
        end
    endtask

    task automatic test_output_stall();
        drain();
        send_idle_pct = 0;
        rsp_hold_left = 200;
        repeat (12) send_random(60);
        drain();
    endtask

    task automatic test_random_mix(input bia_pkg::idx_t cap, input int count,
                                   input int alloc_pct);
        write_capacity(cap);
        repeat (count) send_random(alloc_pct);
        drain();
    endtask

    initial
    begin
        rst_n             = 1'b0;
        req_if.valid      = 1'b0;
        req_if.kind       = bia_pkg::KIND_ALLOC;
        req_if.free_index = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.data       = '0;
        rsp_if.ready      = 1'b0;
        slot_free         = '1;
        hw_mark           = '0;
        cap_setting       = bia_pkg::CAP_RESET;
        errors            = 0;
        cycles            = 0;
        rsp_hold_left     = 0;
        send_idle_pct     = 29;
        rsp_idle_pct      = 79;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_bad_frees();
        test_alloc_free();
        test_capacity_limits();
        test_output_stall();

        send_idle_pct = 29;
        rsp_idle_pct  = 79;
        test_random_mix(bia_pkg::idx_t'($urandom_range(1, 80)), 130, 60);

        send_idle_pct = 79;
        rsp_idle_pct  = 29;
        test_random_mix(bia_pkg::idx_t'($urandom_range(100, 255)), 120, 55);

        send_idle_pct = 0;
        rsp_idle_pct  = 0;
        test_random_mix(bia_pkg::CAP_MAX, 165, 80);

        repeat (20) @(posedge clk);
        if (errors == 0 && expected_rsp_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
